// File: hdl/pfde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_pkg
// shared types, constants and square arithmetic for the playfair encryptor
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int CELLS        = 25;
    localparam int SIDE         = 5;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;

    // request kinds
    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_KEY_END = 2'd1;
    localparam logic [1:0] FUNC_MSG     = 2'd2;
    localparam logic [1:0] FUNC_MSG_END = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] letter;
    } t_in_item;

    typedef struct packed {
        logic [4:0] cipher_letter;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic walk;
        logic pos_rd_b;
        logic sq_rd_1;
        logic cap_pos_a;
        logic cap_pos_b;
        logic cap_c0;
        logic cap_c1;
        logic load_out0;
        logic load_out1;
    } t_dp_cmd;

    typedef struct packed {
        logic pair;
        logic walk;
        logic walk_last;
        logic out_free;
    } t_dp_status;

    // row of a cell 0..24
    function automatic logic [2:0] f_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // first cell of a row, row times side
    function automatic logic [4:0] f_base(input logic [2:0] row);
        return {row, 2'b00} + {2'b00, row};
    endfunction

    function automatic logic [2:0] f_col(input logic [4:0] p, input logic [2:0] row);
        logic [4:0] d;
        d = p - f_base(row);
        return d[2:0];
    endfunction

    function automatic logic [4:0] f_cell(input logic [2:0] row, input logic [2:0] col);
        return f_base(row) + {2'b00, col};
    endfunction

    // step round the ring of five
    function automatic logic [2:0] f_next(input logic [2:0] x);
        return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [4:0] f_to_i(input logic [4:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

endpackage

// File: hdl/pfde_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/pfde_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_dp
// datapath: key square, letter positions, pairing and cipher output register
// ----------------------------------------------------------------------------
module pfde_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfde_pkg::t_in_item   i_in,
    input  pfde_pkg::t_dp_cmd    i_cmd,
    output pfde_pkg::t_dp_status o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output pfde_pkg::t_out_item  o_out
);

    logic        r_used [pfde_pkg::LETTER_COUNT];
    logic [4:0]  r_fill;
    logic        r_key_ready;
    logic [4:0]  r_pend;
    logic        r_pend_valid;
    logic [4:0]  r_walk;
    logic [4:0]  r_a;
    logic [4:0]  r_b;
    logic [4:0]  r_pos_a;
    logic [4:0]  r_pos_b;
    logic [4:0]  r_c0;
    logic [4:0]  r_c1;
    logic        r_ovalid;
    pfde_pkg::t_out_item r_out;

    logic [4:0] l;
    logic       in_range;
    logic       used_l;
    logic       fill_room;
    logic       key_ok;
    logic       walk_start;
    logic       msg_ok;
    logic       pair_msg;
    logic       pair_end;
    logic       walk_ok;
    logic       place;
    logic [4:0] place_val;
    logic [4:0] b_raw;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] addr0, addr1;
    logic [4:0] sq_raddr, sq_rdata;
    logic [4:0] pos_raddr, pos_rdata;

    assign l          = i_in.letter;
    assign in_range   = l < 5'(pfde_pkg::LETTER_COUNT);
    assign used_l     = in_range && r_used[l];
    assign fill_room  = r_fill < 5'(pfde_pkg::CELLS);
    assign key_ok     = (i_in.func == pfde_pkg::FUNC_KEY) && !r_key_ready && in_range
                        && (l != pfde_pkg::LETTER_J) && !used_l && fill_room;
    assign walk_start = (i_in.func == pfde_pkg::FUNC_KEY_END) && !r_key_ready;
    assign msg_ok     = (i_in.func == pfde_pkg::FUNC_MSG) && r_key_ready && in_range;
    assign pair_msg   = msg_ok && r_pend_valid;
    assign pair_end   = (i_in.func == pfde_pkg::FUNC_MSG_END) && r_key_ready && r_pend_valid;
    assign walk_ok    = (r_walk != pfde_pkg::LETTER_J) && !r_used[r_walk] && fill_room;
    assign place      = (i_cmd.take && key_ok) || (i_cmd.walk && walk_ok);
    assign place_val  = i_cmd.walk ? r_walk : l;
    // doubled letter or message end pads with x
    assign b_raw      = (pair_end || (l == r_pend)) ? pfde_pkg::LETTER_X : l;

    assign o_status.pair      = pair_msg || pair_end;
    assign o_status.walk      = walk_start;
    assign o_status.walk_last = r_walk == 5'(pfde_pkg::LETTER_COUNT - 1);
    assign o_status.out_free  = !r_ovalid || !i_out_stall;

    // playfair cell selection
    always_comb begin
        ra = pfde_pkg::f_row(r_pos_a);
        rb = pfde_pkg::f_row(r_pos_b);
        ca = pfde_pkg::f_col(r_pos_a, ra);
        cb = pfde_pkg::f_col(r_pos_b, rb);
        priority if (ra == rb) begin
            addr0 = pfde_pkg::f_cell(ra, pfde_pkg::f_next(ca));
            addr1 = pfde_pkg::f_cell(rb, pfde_pkg::f_next(cb));
        end else if (ca == cb) begin
            addr0 = pfde_pkg::f_cell(pfde_pkg::f_next(ra), ca);
            addr1 = pfde_pkg::f_cell(pfde_pkg::f_next(rb), cb);
        end else begin
            addr0 = pfde_pkg::f_cell(ra, cb);
            addr1 = pfde_pkg::f_cell(rb, ca);
        end
    end

    assign sq_raddr  = i_cmd.sq_rd_1 ? addr1 : addr0;
    assign pos_raddr = i_cmd.pos_rd_b ? r_b : r_a;

    pfde_ram #(.WIDTH(5), .DEPTH(pfde_pkg::CELLS)) u_square (
        .i_clk  (i_clk),
        .i_we   (place),
        .i_waddr(r_fill),
        .i_wdata(place_val),
        .i_raddr(sq_raddr),
        .o_rdata(sq_rdata)
    );

    pfde_ram #(.WIDTH(5), .DEPTH(pfde_pkg::LETTER_COUNT)) u_position (
        .i_clk  (i_clk),
        .i_we   (place),
        .i_waddr(place_val),
        .i_wdata(r_fill),
        .i_raddr(pos_raddr),
        .o_rdata(pos_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pfde_pkg::LETTER_COUNT; k++) begin
                r_used[k] <= 1'b0;
            end
            r_fill       <= '0;
            r_key_ready  <= 1'b0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_walk       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (place) begin
                r_used[place_val] <= 1'b1;
                r_fill            <= r_fill + 5'd1;
            end
            if (i_cmd.take) begin
                if (msg_ok) begin
                    if (!r_pend_valid) begin
                        r_pend       <= l;
                        r_pend_valid <= 1'b1;
                    end else if (l != r_pend) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                if (pair_end) begin
                    r_pend_valid <= 1'b0;
                end
            end
            if (i_cmd.walk) begin
                r_walk <= r_walk + 5'd1;
                if (o_status.walk_last) begin
                    r_key_ready <= 1'b1;
                end
            end
            if (i_cmd.load_out0 || i_cmd.load_out1) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_status.pair) begin
            r_a <= pfde_pkg::f_to_i(r_pend);
            r_b <= pfde_pkg::f_to_i(b_raw);
        end
        if (i_cmd.cap_pos_a) r_pos_a <= pos_rdata;
        if (i_cmd.cap_pos_b) r_pos_b <= pos_rdata;
        if (i_cmd.cap_c0)    r_c0    <= sq_rdata;
        if (i_cmd.cap_c1)    r_c1    <= sq_rdata;
        if (i_cmd.load_out0) begin
            r_out.cipher_letter <= r_c0;
            r_out.last_of_run   <= 1'b0;
        end else if (i_cmd.load_out1) begin
            r_out.cipher_letter <= r_c1;
            r_out.last_of_run   <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

// File: hdl/pfde_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_ctrl
// sequencer for request intake, key fill walk and pair encipherment
// ----------------------------------------------------------------------------
module pfde_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pfde_pkg::t_dp_status i_status,
    output pfde_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WALK   = 4'd1;
    localparam logic [3:0] S_POS_A  = 4'd2;
    localparam logic [3:0] S_POS_B  = 4'd3;
    localparam logic [3:0] S_CAP_B  = 4'd4;
    localparam logic [3:0] S_SQ_0   = 4'd5;
    localparam logic [3:0] S_SQ_1   = 4'd6;
    localparam logic [3:0] S_CAP_1  = 4'd7;
    localparam logic [3:0] S_EMIT_0 = 4'd8;
    localparam logic [3:0] S_EMIT_1 = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid) begin
                    if (i_status.pair) begin
                        n_state = S_POS_A;
                    end else if (i_status.walk) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_POS_A: begin
                n_state = S_POS_B;
            end
            S_POS_B: begin
                o_cmd.pos_rd_b  = 1'b1;
                o_cmd.cap_pos_a = 1'b1;
                n_state         = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.cap_pos_b = 1'b1;
                n_state         = S_SQ_0;
            end
            S_SQ_0: begin
                n_state = S_SQ_1;
            end
            S_SQ_1: begin
                o_cmd.sq_rd_1 = 1'b1;
                o_cmd.cap_c0  = 1'b1;
                n_state       = S_CAP_1;
            end
            S_CAP_1: begin
                o_cmd.sq_rd_1 = 1'b1;
                o_cmd.cap_c1  = 1'b1;
                n_state       = S_EMIT_0;
            end
            S_EMIT_0: begin
                if (i_status.out_free) begin
                    o_cmd.load_out0 = 1'b1;
                    n_state         = S_EMIT_1;
                end
            end
            S_EMIT_1: begin
                if (i_status.out_free) begin
                    o_cmd.load_out1 = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

// File: hdl/playfair_digraph_encryptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// playfair cipher: builds the 5x5 key square and enciphers letter pairs
// ----------------------------------------------------------------------------
//  channel  | valid    | stall    | payload | carries
//  ---------+----------+----------+---------+--------------------------------
//  request  | i_valid  | o_stall  | i_in    | func and letter index
//  result   | o_valid  | i_stall  | o_out   | cipher letter, last of pair
//
// key letter, dropped request or lone message letter: taken in idle, no stall
// key end: runs the fill walk, one alphabet letter a cycle
// enciphered pair: the request port stalls through the pair steps, set by the
//   single read port of each ram (two position reads, then two square reads)
// the result register holds while i_stall is high; the pair waits on it
// reset (synchronous, active low) clears the used marks, fill and pairing
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pfde_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output pfde_pkg::t_out_item o_out
);

    // command and status between sequencer and datapath
    pfde_pkg::t_dp_cmd    cmd;
    pfde_pkg::t_dp_status status;

    // sequencer: takes requests in idle only, runs the walk and pair steps
    pfde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(status),
        .o_cmd   (cmd)
    );

    // datapath: square and position rams, used marks, pending letter,
    // result register
    pfde_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_out_stall(i_stall),
        .o_out_valid(o_valid),
        .o_out      (o_out)
    );

endmodule

// File: hdl/pfde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfde_checker
// port level checks on result pairing and square contents
// ----------------------------------------------------------------------------
module pfde_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input pfde_pkg::t_out_item o_out
);

    // results leave reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result changed");

    // the square never holds j or a code past z
    a_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.cipher_letter < 5'(pfde_pkg::LETTER_COUNT))
                    && (o_out.cipher_letter != pfde_pkg::LETTER_J))
        else $error("cipher letter out of alphabet");

    // first of a pair taken, second follows at once
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_out.last_of_run |=> o_valid && o_out.last_of_run)
        else $error("second letter of pair missing");

    // no request taken while a pair is half delivered
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last_of_run |-> o_stall)
        else $error("request taken mid pair");

endmodule

bind playfair_digraph_encryptor pfde_checker u_pfde_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_out  (o_out)
);
